// ----- rtl/lsh_pkg.sv -----
// Package with the shared sizes and command codes of the sorted LRU key set.
package lsh_pkg;
    localparam int unsigned ENTRIES_DEFAULT = 1024;
    localparam int unsigned KEY_W = 32;
    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_PUT = 1'b1;
endpackage

// ----- rtl/lsh_cmd_if.sv -----
// Channel interface carrying one command word: cmd and key.
interface lsh_cmd_if;
    import lsh_pkg::*;
    logic valid;
    logic ready;
    logic cmd;
    logic [KEY_W-1:0] key;
    modport source (output valid, output cmd, output key, input ready);
    modport sink (input valid, input cmd, input key, output ready);
endinterface

// ----- rtl/lsh_res_if.sv -----
// Channel interface carrying one result word: present.
interface lsh_res_if;
    logic valid;
    logic ready;
    logic present;
    modport source (output valid, output present, input ready);
    modport sink (input valid, input present, output ready);
endinterface

// ----- rtl/lsh_ram.sv -----
// Generic single-port RAM with registered read.
module lsh_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- rtl/lru_sorted_hash_set.sv -----
// Top level of the sorted-array LRU key set with a sequencer over its memories.
// After reset, a clearing pass over every entry loads the initial contents. A
// search is a binary search that probes the sorted key array and then reads
// the final position. A put that misses runs two searches, a ring relink and
// a shift of the sorted array, one moved entry at a time. The input is not
// ready again until the result word has gone into the single output register.
// All work goes through one read or write per memory per cycle.
module lru_sorted_hash_set #(
    parameter int unsigned ENTRIES = lsh_pkg::ENTRIES_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    lsh_cmd_if.sink   cmd_in,
    lsh_res_if.source res_out
);
    import lsh_pkg::*;
    localparam int unsigned AW = $clog2(ENTRIES);
    localparam int unsigned SW = AW + 2;
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    typedef enum logic [5:0] {
        S_INIT, S_IDLE, S_PROBE, S_PWAIT, S_FIN, S_FWAIT, S_DECIDE,
        S_HIT0, S_HITW, S_LINK, S_LINKW,
        S_VRD, S_VRDW, S_VSRCH, S_VKEY, S_VIDX, S_VIDXW,
        S_DCHK, S_DCHKW, S_WRK, S_MVRD, S_MVRW, S_MVWR, S_PUT, S_PUTW, S_OUT
    } state_t;

    // Link-update micro steps for remove s, insert before mr.
    typedef enum logic [3:0] {
        L_RP, L_RN, L_NX, L_W1, L_W2, L_W3, L_W4, L_W5, L_W6, L_DONE
    } link_t;

    state_t state_reg;
    link_t  lk_reg;
    logic [AW-1:0] ctr_reg;
    logic signed [SW-1:0] lo_reg, hi_reg;
    logic [AW-1:0] mid_reg, pos_reg, src_reg, dst_reg, s_reg, mr_reg;
    logic [AW-1:0] p_reg, n_reg, q_reg, tmpi_reg;
    logic [KEY_W-1:0] key_reg, skey_reg, tmpk_reg;
    logic cmd_reg, hit_reg, second_reg, present_reg, valid_reg;

    logic sk_we, si_we, rk_we, rn_we, rp_we;
    logic [AW-1:0] sk_a, si_a, rk_a, rn_a, rp_a, si_wd, rn_wd, rp_wd;
    logic [KEY_W-1:0] sk_wd, rk_wd, sk_rd, rk_rd;
    logic [AW-1:0] si_rd, rn_rd, rp_rd;

    lsh_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_sk (.clk, .we(sk_we), .addr(sk_a),
        .wdata(sk_wd), .rdata(sk_rd));
    lsh_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_si (.clk, .we(si_we), .addr(si_a),
        .wdata(si_wd), .rdata(si_rd));
    lsh_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_rk (.clk, .we(rk_we), .addr(rk_a),
        .wdata(rk_wd), .rdata(rk_rd));
    lsh_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_rn (.clk, .we(rn_we), .addr(rn_a),
        .wdata(rn_wd), .rdata(rn_rd));
    lsh_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_rp (.clk, .we(rp_we), .addr(rp_a),
        .wdata(rp_wd), .rdata(rp_rd));

    logic signed [SW-1:0] sum;
    logic [AW-1:0] midc;
    assign sum = lo_reg + hi_reg;
    assign midc = sum[AW:1];

    assign cmd_in.ready = (state_reg == S_IDLE);
    assign res_out.valid = valid_reg;
    assign res_out.present = present_reg;

    // Memory ports are driven from the current state.
    always_comb
    begin
        sk_we = 1'b0; si_we = 1'b0; rk_we = 1'b0; rn_we = 1'b0; rp_we = 1'b0;
        sk_a = mid_reg; si_a = pos_reg; rk_a = s_reg; rn_a = s_reg; rp_a = s_reg;
        sk_wd = key_reg; si_wd = s_reg; rk_wd = key_reg; rn_wd = s_reg; rp_wd = s_reg;
        unique case (state_reg)
            S_INIT:
            begin
                sk_we = 1'b1; si_we = 1'b1; rk_we = 1'b1; rn_we = 1'b1; rp_we = 1'b1;
                sk_a = ctr_reg; si_a = ctr_reg; rk_a = ctr_reg; rn_a = ctr_reg;
                rp_a = ctr_reg; sk_wd = '0; rk_wd = '0; si_wd = ctr_reg;
                rn_wd = (ctr_reg == LAST) ? '0 : ctr_reg + 1'b1;
                rp_wd = (ctr_reg == '0) ? LAST : ctr_reg - 1'b1;
            end
            S_PROBE: sk_a = midc;
            S_FIN: sk_a = lo_reg[AW-1:0];
            S_HIT0: si_a = pos_reg;
            S_LINK:
            begin
                unique case (lk_reg)
                    L_RP: rp_a = s_reg;
                    L_RN: rn_a = s_reg;
                    L_W1:
                    begin
                        rn_we = 1'b1; rn_a = p_reg; rn_wd = n_reg;
                        rp_we = 1'b1; rp_a = n_reg; rp_wd = p_reg;
                    end
                    L_W2:
                    begin
                        rn_we = 1'b1; rn_a = s_reg; rn_wd = s_reg;
                        rp_we = 1'b1; rp_a = s_reg; rp_wd = s_reg;
                    end
                    L_W3:
                    begin
                        rn_we = 1'b1; rn_a = s_reg; rn_wd = mr_reg;
                        rp_a = mr_reg;
                    end
                    L_W4:
                    begin
                        rp_we = 1'b1; rp_a = s_reg; rp_wd = rp_rd;
                    end
                    L_W5:
                    begin
                        rp_we = 1'b1; rp_a = mr_reg; rp_wd = s_reg;
                    end
                    L_W6:
                    begin
                        rn_we = 1'b1; rn_wd = s_reg;
                        rn_a = (s_reg == mr_reg) ? s_reg : q_reg;
                    end
                    default: ;
                endcase
            end
            S_VRD: rp_a = mr_reg;
            S_VIDX: si_a = src_reg;
            S_DCHK: sk_a = dst_reg;
            S_MVRD:
            begin
                sk_a = (src_reg < dst_reg) ? src_reg + 1'b1 : src_reg - 1'b1;
                si_a = sk_a;
            end
            S_MVWR:
            begin
                sk_we = 1'b1; si_we = 1'b1; sk_a = src_reg; si_a = src_reg;
                sk_wd = tmpk_reg; si_wd = tmpi_reg;
            end
            S_PUT:
            begin
                sk_we = 1'b1; si_we = 1'b1; sk_a = dst_reg; si_a = dst_reg;
                sk_wd = key_reg; si_wd = s_reg;
                rk_we = 1'b1; rk_a = s_reg; rk_wd = key_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            lk_reg <= L_RP;
            ctr_reg <= '0;
            mr_reg <= '0;
            valid_reg <= 1'b0;
            present_reg <= 1'b0;
        end
        else
        begin
            if (valid_reg && res_out.ready && state_reg != S_OUT)
            begin
                valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT:
                begin
                    ctr_reg <= ctr_reg + 1'b1;
                    if (ctr_reg == LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_in.valid)
                    begin
                        cmd_reg <= cmd_in.cmd;
                        key_reg <= cmd_in.key;
                        skey_reg <= cmd_in.key;
                        second_reg <= 1'b0;
                        lo_reg <= '0;
                        hi_reg <= SW'(ENTRIES - 1);
                        state_reg <= S_PROBE;
                    end
                end
                S_PROBE:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        mid_reg <= midc;
                        state_reg <= S_PWAIT;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_PWAIT:
                begin
                    if (sk_rd == skey_reg)
                    begin
                        lo_reg <= SW'(mid_reg);
                        hi_reg <= SW'(mid_reg);
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        if (sk_rd < skey_reg)
                        begin
                            lo_reg <= SW'(mid_reg) + 1'b1;
                        end
                        else
                        begin
                            hi_reg <= SW'(mid_reg) - 1'b1;
                        end
                        state_reg <= S_PROBE;
                    end
                end
                S_FIN: state_reg <= S_FWAIT;
                S_FWAIT:
                begin
                    if (second_reg)
                    begin
                        src_reg <= lo_reg[AW-1:0];
                        state_reg <= S_VIDX;
                    end
                    else
                    begin
                        pos_reg <= lo_reg[AW-1:0];
                        dst_reg <= lo_reg[AW-1:0];
                        hit_reg <= (sk_rd == key_reg);
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (cmd_reg == CMD_QUERY)
                    begin
                        state_reg <= S_OUT;
                    end
                    else if (hit_reg)
                    begin
                        state_reg <= S_HIT0;
                    end
                    else
                    begin
                        state_reg <= S_VRD;
                    end
                end
                S_HIT0: state_reg <= S_HITW;
                S_HITW:
                begin
                    s_reg <= si_rd;
                    if (si_rd == mr_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        lk_reg <= L_RP;
                        state_reg <= S_LINK;
                    end
                end
                S_LINK:
                begin
                    unique case (lk_reg)
                        L_RP: lk_reg <= L_RN;
                        L_RN:
                        begin
                            p_reg <= rp_rd;
                            lk_reg <= L_NX;
                        end
                        L_NX:
                        begin
                            n_reg <= rn_rd;
                            lk_reg <= L_W1;
                        end
                        L_W1: lk_reg <= L_W2;
                        L_W2: lk_reg <= L_W3;
                        L_W3: lk_reg <= L_W4;
                        L_W4:
                        begin
                            q_reg <= rp_rd;
                            lk_reg <= L_W5;
                        end
                        L_W5: lk_reg <= L_W6;
                        L_W6:
                        begin
                            lk_reg <= L_DONE;
                            state_reg <= S_LINKW;
                        end
                        default: lk_reg <= L_DONE;
                    endcase
                end
                S_LINKW:
                begin
                    mr_reg <= s_reg;
                    state_reg <= hit_reg ? S_OUT : S_DCHK;
                end
                S_VRD: state_reg <= S_VRDW;
                S_VRDW:
                begin
                    s_reg <= rp_rd;
                    state_reg <= S_VSRCH;
                end
                S_VSRCH: state_reg <= S_VKEY;
                S_VKEY:
                begin
                    skey_reg <= rk_rd;
                    second_reg <= 1'b1;
                    lo_reg <= '0;
                    hi_reg <= SW'(ENTRIES - 1);
                    state_reg <= S_PROBE;
                end
                S_VIDX: state_reg <= S_VIDXW;
                S_VIDXW:
                begin
                    if (si_rd != s_reg)
                    begin
                        s_reg <= si_rd;
                        lk_reg <= L_RP;
                        state_reg <= S_LINK;
                    end
                    else
                    begin
                        mr_reg <= s_reg;
                        state_reg <= S_DCHK;
                    end
                end
                S_DCHK: state_reg <= S_DCHKW;
                S_DCHKW:
                begin
                    if (src_reg < dst_reg && !(sk_rd < key_reg))
                    begin
                        dst_reg <= dst_reg - 1'b1;
                    end
                    else if (dst_reg < src_reg && sk_rd < key_reg)
                    begin
                        dst_reg <= dst_reg + 1'b1;
                    end
                    state_reg <= S_WRK;
                end
                S_WRK: state_reg <= (src_reg == dst_reg) ? S_PUT : S_MVRD;
                S_MVRD: state_reg <= S_MVRW;
                S_MVRW:
                begin
                    tmpk_reg <= sk_rd;
                    tmpi_reg <= si_rd;
                    state_reg <= S_MVWR;
                end
                S_MVWR:
                begin
                    src_reg <= (src_reg < dst_reg) ? src_reg + 1'b1 : src_reg - 1'b1;
                    state_reg <= S_WRK;
                end
                S_PUT: state_reg <= S_PUTW;
                S_PUTW: state_reg <= S_OUT;
                S_OUT:
                begin
                    if (!valid_reg || res_out.ready)
                    begin
                        valid_reg <= 1'b1;
                        present_reg <= hit_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
